/* rtl/branch_transition_recorder_defines.svh */
// ---------------------------------------------------------------------------
// assertion macros for the branch transition recorder checker
// ---------------------------------------------------------------------------
`ifndef BRANCH_TRANSITION_RECORDER_DEFINES_SVH
`define BRANCH_TRANSITION_RECORDER_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define BTR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define BTR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/btr_pkg.sv */
// ---------------------------------------------------------------------------
// btr_pkg
// shared types and constants of the branch transition recorder
// ---------------------------------------------------------------------------
package btr_pkg;

  // default number of table entries
  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  // request kinds
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // entry mark bits
  localparam logic [1:0] MARK_PENDING = 2'b01;
  localparam logic [1:0] MARK_JUMPED  = 2'b10;
  localparam logic [1:0] MARK_BOTH    = MARK_PENDING | MARK_JUMPED;

  // saturation value of the hit count
  localparam logic [31:0] TEMP_MAX = 32'hFFFF_FFFF;

  // one table entry as held in memory
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] tgt;
    logic [31:0] temp;
    logic [1:0]  marks;
  } entry_t;

  // memory port enables from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

/* rtl/btr_if.sv */
// ---------------------------------------------------------------------------
// btr_in_if / btr_out_if
// valid/ready channels for requests and read results
// ---------------------------------------------------------------------------
interface btr_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [9:0]         site_id;
  logic signed [31:0] source_block;
  logic signed [31:0] target_block;

  modport source (output valid, kind, site_id, source_block, target_block, input ready);
  modport sink   (input valid, kind, site_id, source_block, target_block, output ready);
endinterface

interface btr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] entry_source;
  logic signed [31:0] entry_target;
  logic [31:0]        entry_temperature;
  logic               entry_present;

  modport source (output valid, entry_source, entry_target, entry_temperature,
                  entry_present, input ready);
  modport sink   (input valid, entry_source, entry_target, entry_temperature,
                  entry_present, output ready);
endinterface

/* rtl/btr_table.sv */
// ---------------------------------------------------------------------------
// btr_table
// entry memory, one write port and two registered read ports
// ---------------------------------------------------------------------------
module btr_table #(
  parameter  int unsigned TABLE_DEPTH = btr_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW          = $clog2(TABLE_DEPTH)
) (
  input  logic             clk,
  input  btr_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]    waddr,
  input  btr_pkg::entry_t  wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output btr_pkg::entry_t  rdata_a,
  output btr_pkg::entry_t  rdata_b
);
  import btr_pkg::*;

  entry_t mem [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, data held until the next read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* rtl/btr_seq.sv */
// ---------------------------------------------------------------------------
// btr_seq
// request sequencer: clearing sweep, table reads and read-modify-write of table entries
// ---------------------------------------------------------------------------
module btr_seq #(
  parameter  int unsigned TABLE_DEPTH = btr_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW          = $clog2(TABLE_DEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  // request side
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [9:0]         in_site,
  input  logic [31:0]        in_src,
  input  logic [31:0]        in_dst,
  // memory side
  output btr_pkg::mem_ctl_t  mem_ctl,
  output logic [AW-1:0]      waddr,
  output btr_pkg::entry_t    wdata,
  output logic [AW-1:0]      raddr_a,
  output logic [AW-1:0]      raddr_b,
  input  btr_pkg::entry_t    rdata_a,
  input  btr_pkg::entry_t    rdata_b,
  // result side
  output logic               resp_valid,
  input  logic               resp_ready,
  output btr_pkg::entry_t    resp_entry,
  output logic               resp_present
);
  import btr_pkg::*;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_WR   = 3'd3;
  localparam logic [2:0] ST_RESP = 3'd4;

  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
  localparam logic [AW-1:0] ONE_ADDR  = AW'(1);

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] addr_r;
  logic          in_range_r;
  logic          skip_r;
  logic          site_zero_r;
  logic [31:0]   src_r, dst_r;
  entry_t        s_word_r, s_word_nxt;
  logic [31:0]   last_source_r;
  logic [AW-1:0] last_site_r;
  logic          last_valid_r;

  logic          accept;
  logic          in_skip;
  logic          in_range;
  logic [AW-1:0] in_addr;
  entry_t        below_word;
  entry_t        last_word;
  entry_t        base_word;
  logic          dst_positive;

  // request decode
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_skip  = (in_src == last_source_r);
  assign in_range = (32'(in_site) < 32'(TABLE_DEPTH));
  assign in_addr  = AW'(in_site);

  // entry below the site on a skip: erase if pending, then count down if the site has jumped
  always_comb begin
    below_word = rdata_b;
    if ((rdata_b.marks & MARK_PENDING) != 2'b00) begin
      below_word = '0;
    end
    if (((rdata_a.marks & MARK_JUMPED) != 2'b00) && (below_word.temp != 32'd0)) begin
      below_word.temp = below_word.temp + 32'hFFFF_FFFF;
    end
  end

  // previous entry loses its pending mark
  always_comb begin
    last_word       = rdata_b;
    last_word.marks = rdata_b.marks & ~MARK_PENDING;
  end

  // new value of the recorded entry, forwarding the pending clear onto itself
  assign dst_positive = !dst_r[31] && (dst_r != 32'd0);

  always_comb begin
    base_word = rdata_a;
    if (!skip_r && last_valid_r && (last_site_r == addr_r)) begin
      base_word.marks = rdata_a.marks & ~MARK_PENDING;
    end
    s_word_nxt     = base_word;
    s_word_nxt.src = src_r;
    s_word_nxt.tgt = dst_r;
    if (base_word.temp != TEMP_MAX) begin
      s_word_nxt.temp = base_word.temp + 32'd1;
    end
    if (dst_positive && ((base_word.marks & MARK_JUMPED) == 2'b00)) begin
      s_word_nxt.marks = MARK_BOTH;
    end
  end

  // read result
  assign resp_entry   = in_range_r ? rdata_a : '0;
  assign resp_present = (resp_entry.src != 32'd0) || (resp_entry.tgt != 32'd0);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    mem_ctl.rd_en  = accept;
    mem_ctl.wr_en  = 1'b0;
    waddr          = addr_r;
    wdata          = s_word_r;
    raddr_a        = in_addr;
    raddr_b        = in_skip ? (in_addr - ONE_ADDR) : last_site_r;
    resp_valid     = 1'b0;
    case (state_r)
      ST_CLR: begin
        mem_ctl.wr_en = 1'b1;
        waddr         = clr_cnt_r;
        wdata         = '0;
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_READ) begin
            state_nxt = ST_RESP;
          end else if (in_range) begin
            state_nxt = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (skip_r) begin
          mem_ctl.wr_en = !site_zero_r;
          waddr         = addr_r - ONE_ADDR;
          wdata         = below_word;
        end else begin
          mem_ctl.wr_en = last_valid_r;
          waddr         = last_site_r;
          wdata         = last_word;
        end
        state_nxt = ST_WR;
      end
      ST_WR: begin
        mem_ctl.wr_en = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_RESP: begin
        resp_valid = 1'b1;
        if (resp_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLR;
      clr_cnt_r     <= '0;
      last_source_r <= '0;
      last_site_r   <= '0;
      last_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_cnt_r <= clr_cnt_r + ONE_ADDR;
      end
      if (state_r == ST_WR) begin
        last_source_r <= src_r;
        last_site_r   <= addr_r;
        last_valid_r  <= 1'b1;
      end
    end
  end

  // request and entry payload
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r      <= in_addr;
      in_range_r  <= in_range;
      skip_r      <= in_skip;
      site_zero_r <= (in_site == 10'd0);
      src_r       <= in_src;
      dst_r       <= in_dst;
    end
    if (state_r == ST_MOD) begin
      s_word_r <= s_word_nxt;
    end
  end

endmodule

/* rtl/branch_transition_recorder.sv */
// ---------------------------------------------------------------------------
// branch_transition_recorder
// coverage table of control-flow transitions indexed by site id
// ---------------------------------------------------------------------------
//  channel  | dir | fields                                          | use
//  in_chan  | in  | kind, site_id, source_block, target_block       | record or read request
//  out_chan | out | entry_source, entry_target, entry_temperature,  | one result per read
//           |     | entry_present                                   |
//
//  a record reads both entries together, then makes two writes through the
//  single memory write port; an out-of-range record writes nothing
//  a read is held in the response state until the output register frees
//  after reset a clearing pass writes all TABLE_DEPTH entries, one per
//  cycle, and in_chan.ready stays low until the pass is done
//  a full output register parks the next read, and then in_chan.ready stays low
// ---------------------------------------------------------------------------
module branch_transition_recorder #(
  parameter int unsigned TABLE_DEPTH = btr_pkg::TABLE_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  btr_in_if.sink   in_chan,
  btr_out_if.source out_chan
);
  import btr_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  entry_t        wdata, rdata_a, rdata_b;
  logic          resp_valid, resp_ready, resp_present;
  entry_t        resp_entry;

  logic          out_valid_r;
  logic [31:0]   out_src_r, out_tgt_r, out_temp_r;
  logic          out_present_r;

  btr_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_kind      (in_chan.kind),
    .in_site      (in_chan.site_id),
    .in_src       (in_chan.source_block),
    .in_dst       (in_chan.target_block),
    .mem_ctl      (mem_ctl),
    .waddr        (waddr),
    .wdata        (wdata),
    .raddr_a      (raddr_a),
    .raddr_b      (raddr_b),
    .rdata_a      (rdata_a),
    .rdata_b      (rdata_b),
    .resp_valid   (resp_valid),
    .resp_ready   (resp_ready),
    .resp_entry   (resp_entry),
    .resp_present (resp_present)
  );

  btr_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .ctl     (mem_ctl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // output register frees when empty or taken this cycle
  assign resp_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_ready) begin
      out_valid_r <= resp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_valid && resp_ready) begin
      out_src_r     <= resp_entry.src;
      out_tgt_r     <= resp_entry.tgt;
      out_temp_r    <= resp_entry.temp;
      out_present_r <= resp_present;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.entry_source      = out_src_r;
  assign out_chan.entry_target      = out_tgt_r;
  assign out_chan.entry_temperature = out_temp_r;
  assign out_chan.entry_present     = out_present_r;

endmodule

/* rtl/btr_chk.sv */
// ---------------------------------------------------------------------------
// btr_chk
// port-level checks of the branch transition recorder
// ---------------------------------------------------------------------------
`include "branch_transition_recorder_defines.svh"

module btr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_source,
  input logic [31:0] out_target,
  input logic [31:0] out_temp,
  input logic        out_present
);
  import btr_pkg::*;

  // a stalled result stays offered
  `BTR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // a stalled result keeps its payload
  `BTR_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable({out_source, out_target, out_temp, out_present}), "result changed while stalled")

  // one request at a time: busy right after each accept
  `BTR_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request accepted while busy")

  // a fresh result stems from an accepted read request, by way of the response state
  `BTR_ASSERT_IMP(a_result_from_read, $rose(out_valid), $past(in_valid && in_ready && (in_kind == KIND_READ), 2), "result without a read request")

endmodule

bind branch_transition_recorder btr_chk u_btr_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .in_kind     (in_chan.kind),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_source  (out_chan.entry_source),
  .out_target  (out_chan.entry_target),
  .out_temp    (out_chan.entry_temperature),
  .out_present (out_chan.entry_present)
);

/* tb/branch_transition_recorder_tb.sv */
// ---------------------------------------------------------------------------
// branch_transition_recorder_tb
// Drives record and read requests into the transition recorder and checks
// every read result against a cycle-free model of the coverage table. The
// sequence runs directed corner cases first, then random runs of records
// along neighbouring sites followed by reads, and single requests. Both
// channels idle at random, the result side is held off long enough to
// back up the input, and the sender drains everything once, then goes on.
// ---------------------------------------------------------------------------
module branch_transition_recorder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btr_pkg::*;

  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;

  // one read result as seen on the output channel
  typedef struct packed {
    logic signed [31:0] src;
    logic signed [31:0] tgt;
    logic [31:0]        temp;
    logic               present;
  } readback_t;

  // coverage table model and the queue of reads still owed by the block
  class coverage_table_tracker;
    logic [31:0] src_tab   [DEPTH];
    logic [31:0] tgt_tab   [DEPTH];
    logic [31:0] temp_tab  [DEPTH];
    logic [1:0]  marks_tab [DEPTH];
    logic [31:0] last_src;
    logic [9:0]  last_site;
    bit          last_valid;
    readback_t   pending_reads[$];
    int unsigned failures;

    function new();
      foreach (src_tab[i]) begin
        src_tab[i]   = '0;
        tgt_tab[i]   = '0;
        temp_tab[i]  = '0;
        marks_tab[i] = '0;
      end
      last_src   = '0;
      last_site  = '0;
      last_valid = 1'b0;
      failures   = 0;
    endfunction

    // apply one transition to the table
    function void record(logic [9:0] site, logic [31:0] src, logic [31:0] tgt);
      logic [9:0] below;
      if (int'(site) >= DEPTH) return;
      if (src == last_src) begin
        // skip: erase a pending neighbour, cool it if this site has jumped
        if (site != 0) begin
          below = site - 10'd1;
          if ((marks_tab[below] & MARK_PENDING) != 2'b00) begin
            src_tab[below]   = '0;
            tgt_tab[below]   = '0;
            temp_tab[below]  = '0;
            marks_tab[below] = '0;
          end
          if ((marks_tab[site] & MARK_JUMPED) != 2'b00 && temp_tab[below] != 0)
            temp_tab[below] = temp_tab[below] - 32'd1;
        end
      end else if (last_valid && int'(last_site) < DEPTH) begin
        marks_tab[last_site] = marks_tab[last_site] & ~MARK_PENDING;
      end
      src_tab[site] = src;
      tgt_tab[site] = tgt;
      if (temp_tab[site] != TEMP_MAX) temp_tab[site] = temp_tab[site] + 32'd1;
      // positive destination marks the first jump
      if (!tgt[31] && tgt != 0 && (marks_tab[site] & MARK_JUMPED) == 2'b00)
        marks_tab[site] = MARK_BOTH;
      last_src   = src;
      last_site  = site;
      last_valid = 1'b1;
    endfunction

    // accepted request: update the table or queue the expected read
    function void note_request(logic kind, logic [9:0] site, logic [31:0] src,
                               logic [31:0] tgt);
      readback_t exp_entry;
      if (kind == KIND_RECORD) begin
        record(site, src, tgt);
      end else begin
        exp_entry = '0;
        if (int'(site) < DEPTH) begin
          exp_entry.src     = src_tab[site];
          exp_entry.tgt     = tgt_tab[site];
          exp_entry.temp    = temp_tab[site];
          exp_entry.present = (src_tab[site] != 0) || (tgt_tab[site] != 0);
        end
        pending_reads.push_back(exp_entry);
      end
    endfunction

    // compare one result with the oldest outstanding read
    function void check_entry(readback_t got);
      readback_t exp_entry;
      if (pending_reads.size() == 0) begin
        $error("read result with no read request outstanding");
        failures++;
        return;
      end
      exp_entry = pending_reads.pop_front();
      if (got.src !== exp_entry.src) begin
        $error("entry_source: expected %0d, got %0d", exp_entry.src, got.src);
        failures++;
      end
      if (got.tgt !== exp_entry.tgt) begin
        $error("entry_target: expected %0d, got %0d", exp_entry.tgt, got.tgt);
        failures++;
      end
      if (got.temp !== exp_entry.temp) begin
        $error("entry_temperature: expected %0d, got %0d", exp_entry.temp, got.temp);
        failures++;
      end
      if (got.present !== exp_entry.present) begin
        $error("entry_present: expected %0d, got %0d", exp_entry.present, got.present);
        failures++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_reads.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  btr_in_if  in_chan();
  btr_out_if out_chan();

  branch_transition_recorder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  coverage_table_tracker tracker = new();

  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          rx_hold = 1'b0;
  int unsigned rx_wait = 0;
  int unsigned requests_sent = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle cycles before the next request or result
  function automatic int unsigned draw_wait(bit calm);
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  // sites mostly from a small window so that entries get revisited
  function automatic logic [9:0] pick_site();
    if ($urandom_range(0, 4) == 0) return 10'($urandom_range(0, 1023));
    return 10'($urandom_range(0, 23));
  endfunction

  // block numbers biased to extremes and a small pool
  function automatic logic [31:0] pick_block();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'hFFFF_FFFF;
      4, 5:    return 32'($urandom_range(1, 4));
      default: return $urandom();
    endcase
  endfunction

  // result side: ready with random stalls, check on every handshake
  always @(negedge clk) begin
    if (rx_hold || rx_wait != 0) begin
      out_chan.ready = 1'b0;
      if (!rx_hold) rx_wait--;
    end else begin
      out_chan.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      tracker.check_entry('{out_chan.entry_source, out_chan.entry_target,
                            out_chan.entry_temperature, out_chan.entry_present});
      rx_wait = draw_wait(rx_calm);
    end
  end

  // offer one request and wait for it to be taken
  task automatic send_request(logic kind, logic [9:0] site, logic [31:0] src,
                              logic [31:0] tgt);
    int unsigned gap;
    gap = draw_wait(tx_calm);
    @(negedge clk);
    if (gap != 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.kind         = kind;
    in_chan.site_id      = site;
    in_chan.source_block = src;
    in_chan.target_block = tgt;
    in_chan.valid        = 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    tracker.note_request(kind, site, src, tgt);
    requests_sent++;
  endtask

  // lower valid and wait for every outstanding read to come back
  task automatic drain_reads();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // random traffic: runs of records on neighbouring sites, then reads, among single records and reads
  task automatic send_mix(int unsigned upto);
    int unsigned choice;
    int unsigned run_len;
    logic [9:0]  base;
    logic [31:0] src;
    logic [31:0] tgt;
    while (requests_sent < upto) begin
      choice = $urandom_range(0, 9);
      if (choice < 6) begin
        base    = pick_site();
        run_len = $urandom_range(2, 6);
        src     = pick_block();
        for (int i = 0; i < run_len; i++) begin
          // occasionally break the run with a fresh source
          if ($urandom_range(0, 7) == 0) src = pick_block();
          tgt = ($urandom_range(0, 3) != 0) ? 32'($urandom_range(1, 4000)) : pick_block();
          send_request(KIND_RECORD, base + 10'(i), src, tgt);
        end
        repeat ($urandom_range(1, 3))
          send_request(KIND_READ, base - 10'd1 + 10'($urandom_range(0, run_len)),
                       $urandom(), $urandom());
      end else if (choice < 8) begin
        send_request(KIND_RECORD, pick_site(), pick_block(), pick_block());
      end else begin
        send_request(KIND_READ, pick_site(), $urandom(), $urandom());
      end
    end
  endtask

  // main sequence
  initial begin
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.kind         = KIND_RECORD;
    in_chan.site_id      = '0;
    in_chan.source_block = '0;
    in_chan.target_block = '0;
    out_chan.ready       = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // cleared table at both ends
    send_request(KIND_READ,   10'd0,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_READ,   10'd1023, 32'h0,         32'h0);
    // first record with source zero counts as a skip at site zero
    send_request(KIND_RECORD, 10'd0,    32'd0,         32'd5);
    send_request(KIND_READ,   10'd0,    32'd0,         32'd0);
    // skip erases the pending entry below
    send_request(KIND_RECORD, 10'd1,    32'd0,         32'd7);
    send_request(KIND_READ,   10'd0,    32'd0,         32'd0);
    send_request(KIND_READ,   10'd1,    32'd0,         32'd0);
    // skip over a jumped site cools the entry below
    send_request(KIND_RECORD, 10'd5,    32'd11,        32'd3);
    send_request(KIND_RECORD, 10'd9,    32'd12,        32'd4);
    send_request(KIND_RECORD, 10'd4,    32'd13,        32'hFFFF_FFFF);
    send_request(KIND_RECORD, 10'd5,    32'd13,        32'd3);
    send_request(KIND_READ,   10'd4,    32'd0,         32'd0);
    send_request(KIND_READ,   10'd5,    32'd0,         32'd0);
    send_request(KIND_READ,   10'd9,    32'd0,         32'd0);
    // extreme block numbers at the top of the table
    send_request(KIND_RECORD, 10'd1023, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(KIND_RECORD, 10'd1022, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(KIND_RECORD, 10'd1023, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(KIND_READ,   10'd1022, 32'd0,         32'd0);
    send_request(KIND_READ,   10'd1023, 32'd0,         32'd0);
    send_request(KIND_RECORD, 10'd512,  32'hFFFF_FFFF, 32'd0);
    send_request(KIND_READ,   10'd512,  32'd0,         32'd0);

    send_mix(450);

    // hold the result side off while requests keep coming
    fork
      begin
        rx_hold = 1'b1;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    tx_calm = 1'b1;
    send_mix(requests_sent + 40);
    tx_calm = 1'b0;

    // pause until every read has come back
    drain_reads();

    // back-to-back stretch on both sides
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    send_mix(requests_sent + 250);
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    send_mix(1250);

    drain_reads();
    repeat (20) @(posedge clk);
    if (tracker.failures == 0 && tracker.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
